@@ hdl/ocsr_pkg.sv @@
// Shared types, widths and the binomial table builder for the occupation state ranker.
package ocsr_pkg;

  // Field widths of the transaction payloads
  localparam int OCC_FIELDS = 7;
  localparam int OCC_W      = 4;
  localparam int ADD_W      = 3;
  localparam int IDX_W      = 18;
  // Running particle count: at most seven full orbitals plus the created particle
  localparam int CNT_W      = 7;
  // Saturated configuration widths (particles up to 31, orbitals up to 31)
  localparam int NP_W       = 5;
  localparam int M_W        = 5;
  localparam int CFG_W      = 4;
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;
  // Number of Pascal columns the table builder keeps (largest k plus one)
  localparam int PASCAL_N   = 64;

  // One item in flight through the orbital stages
  typedef struct packed {
    logic [OCC_FIELDS-1:0][OCC_W-1:0] occ;
    logic [ADD_W-1:0]                 added;
    logic [CNT_W-1:0]                 count;
    logic [IDX_W-1:0]                 sum;
  } ocsr_item_t;

  // Saturated configuration seen by every stage
  typedef struct packed {
    logic [NP_W-1:0] np;
    logic [M_W-1:0]  m;
  } ocsr_cfg_t;

  // C(n,k) modulo 2^IDX_W, built row by row from Pascal's rule
  function automatic logic [IDX_W-1:0] binom_mod(input int n, input int k);
    logic [IDX_W-1:0] row [PASCAL_N];
    for (int c = 0; c < PASCAL_N; c++) begin
      row[c] = '0;
    end
    row[0] = IDX_W'(1);
    for (int r = 1; r <= n; r++) begin
      for (int c = PASCAL_N - 1; c > 0; c--) begin
        if (c <= r) begin
          row[c] = row[c] + row[c-1];
        end
      end
    end
    return row[k];
  endfunction

endpackage

@@ hdl/ocsr_cfg.sv @@
// APB-style register file holding particle and orbital counts, with saturation.
module ocsr_cfg
  import ocsr_pkg::*;
#(
  parameter int MAX_ORBITALS  = 8,
  parameter int MAX_PARTICLES = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ocsr_cfg_t          cfg
);

  localparam logic REG_NUM_PARTICLES = 1'b0;
  localparam logic REG_NUM_ORBITALS  = 1'b1;

  logic [CFG_W-1:0] np_r, np_nxt;
  logic [CFG_W-1:0] m_r, m_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the register write
  always_comb begin
    np_nxt = np_r;
    m_nxt  = m_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_NUM_PARTICLES: np_nxt = pwdata[CFG_W-1:0];
        REG_NUM_ORBITALS:  m_nxt  = pwdata[CFG_W-1:0];
        default:           np_nxt = np_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r <= '0;
      m_r  <= CFG_W'(8);
    end else begin
      np_r <= np_nxt;
      m_r  <= m_nxt;
    end
  end

  // Read back the stored value
  always_comb begin
    unique case (paddr[2])
      REG_NUM_PARTICLES: prdata = PDATA_W'(np_r);
      REG_NUM_ORBITALS:  prdata = PDATA_W'(m_r);
      default:           prdata = '0;
    endcase
  end

  // Clamp to the synthesized limits
  always_comb begin
    cfg.np = (int'(np_r) > MAX_PARTICLES) ? NP_W'(MAX_PARTICLES) : NP_W'(np_r);
    cfg.m  = (int'(m_r) > MAX_ORBITALS) ? M_W'(MAX_ORBITALS) : M_W'(m_r);
  end

endmodule

@@ hdl/ocsr_stage.sv @@
// One orbital stage: update the particle count and add one binomial term.
module ocsr_stage
  import ocsr_pkg::*;
#(
  parameter int ORB           = 0,
  parameter int MAX_ORBITALS  = 8,
  parameter int MAX_PARTICLES = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  ocsr_cfg_t  cfg,
  input  logic       valid_i,
  input  ocsr_item_t item_i,
  output logic       valid_o,
  output ocsr_item_t item_o
);

  localparam int KN  = MAX_ORBITALS - 1;
  localparam int JN  = MAX_PARTICLES + 1;
  localparam int KIW = (KN > 1) ? $clog2(KN) : 1;
  localparam int JIW = $clog2(JN);

  // Table of C(j+k, k), row k-1, column j
  logic [IDX_W-1:0] tbl [KN][JN];

  for (genvar kk = 0; kk < KN; kk++) begin : g_row
    for (genvar jj = 0; jj < JN; jj++) begin : g_col
      localparam logic [IDX_W-1:0] ENTRY = binom_mod(jj + kk + 1, kk + 1);
      assign tbl[kk][jj] = ENTRY;
    end
  end

  logic [OCC_W-1:0]       occ_v;
  logic                   hit;
  logic [CNT_W-1:0]       count_upd;
  logic signed [CNT_W:0]  diff;
  logic                   active;
  logic [M_W-1:0]         kx;
  logic [KIW-1:0]         kidx;
  logic [JIW-1:0]         jidx;
  logic [IDX_W-1:0]       term;
  ocsr_item_t             item_nxt;
  ocsr_item_t             item_r;
  logic                   valid_r;

  // Orbitals past the last input field read as empty
  if (ORB < OCC_FIELDS) begin : g_occ
    assign occ_v = item_i.occ[ORB];
  end else begin : g_no_occ
    assign occ_v = '0;
  end

  // Count up to this orbital, then look up C(np + k - count, k)
  always_comb begin
    hit       = (int'(item_i.added) == ORB);
    count_upd = item_i.count + CNT_W'(occ_v) + CNT_W'(hit);
    diff      = $signed({1'b0, CNT_W'(cfg.np)}) - $signed({1'b0, count_upd});
    active    = (int'(cfg.m) > ORB + 1);
    kx        = cfg.m - M_W'(ORB + 2);
    kidx      = kx[KIW-1:0];
    jidx      = diff[JIW-1:0];
    term      = (active && !diff[CNT_W]) ? tbl[kidx][jidx] : '0;
    item_nxt       = item_i;
    item_nxt.count = count_upd;
    item_nxt.sum   = item_i.sum + term;
  end

  // Advance with the pipeline, hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

@@ hdl/occupation_state_ranker_core.sv @@
// Top level of the occupation state ranker: input register, orbital stages, output register.
//
// Usage: an input transaction carries the occupations of orbitals 0..6 and the
// orbital that receives one created particle; the result transaction carries the
// reverse-lexicographic rank of the resulting number state (low 18 bits).
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Particle and orbital counts are written over the APB-style port
// (byte address 0 and 4) while no transaction is in flight; the user must keep to
// this, as the block itself does not enforce it.
// Path: the input register, one register stage for each of the MAX_ORBITALS - 1
// orbitals that the rank loop visits, and the output register.
// Throughput: one transaction per cycle when the receiver does not stall.
// Reset: all stage valid bits clear, the particle count goes to 0 and the
// orbital count to 8; no result is pending afterwards.
// Stall: while a result waits with out_stall high, the whole pipeline holds
// and in_stall is raised; nothing is dropped or duplicated.
module occupation_state_ranker_core
  import ocsr_pkg::*;
#(
  parameter int MAX_ORBITALS  = 8,
  parameter int MAX_PARTICLES = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OCC_W-1:0]   in_occ_0,
  input  logic [OCC_W-1:0]   in_occ_1,
  input  logic [OCC_W-1:0]   in_occ_2,
  input  logic [OCC_W-1:0]   in_occ_3,
  input  logic [OCC_W-1:0]   in_occ_4,
  input  logic [OCC_W-1:0]   in_occ_5,
  input  logic [OCC_W-1:0]   in_occ_6,
  input  logic [ADD_W-1:0]   in_added_orbital,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_rank,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NSTG = MAX_ORBITALS - 1;

  ocsr_cfg_t        cfg;
  logic             adv;
  logic [NSTG:0]    stg_vld;
  ocsr_item_t       stg_item [NSTG+1];
  ocsr_item_t       in_item;
  logic             in_vld_r;
  ocsr_item_t       in_item_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_index_r;

  ocsr_cfg #(
    .MAX_ORBITALS  (MAX_ORBITALS),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold everything while the result register is blocked
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Pack the incoming transaction
  always_comb begin
    in_item.occ[0] = in_occ_0;
    in_item.occ[1] = in_occ_1;
    in_item.occ[2] = in_occ_2;
    in_item.occ[3] = in_occ_3;
    in_item.occ[4] = in_occ_4;
    in_item.occ[5] = in_occ_5;
    in_item.occ[6] = in_occ_6;
    in_item.added  = in_added_orbital;
    in_item.count  = '0;
    in_item.sum    = '0;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_item_r <= in_item;
    end
  end

  assign stg_vld[0]  = in_vld_r;
  assign stg_item[0] = in_item_r;

  // One stage per orbital that the rank loop visits
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    ocsr_stage #(
      .ORB           (s),
      .MAX_ORBITALS  (MAX_ORBITALS),
      .MAX_PARTICLES (MAX_PARTICLES)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cfg     (cfg),
      .valid_i (stg_vld[s]),
      .item_i  (stg_item[s]),
      .valid_o (stg_vld[s+1]),
      .item_o  (stg_item[s+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_r <= stg_item[NSTG].sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rank  = out_index_r;

  // A blocked result freezes every stage valid bit
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(stg_vld))
    else $error("pipeline moved while the result was stalled");

  // A new result only follows a valid item in the last stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stg_vld[NSTG]))
    else $error("result appeared without a finished item");

  // Running count stays within seven full orbitals plus one
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld[NSTG] |-> (int'(stg_item[NSTG].count) <= OCC_FIELDS * 15 + 1))
    else $error("particle count out of range");

endmodule
